// ===== sv/dpso_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date plus seconds offset: shared package
// Widths, command and status types, payload structs and calendar helpers.
// ----------------------------------------------------------------------------
package dpso_pkg;

	localparam int OFFSET_BITS = 34;
	localparam int WS_W        = 34;
	localparam int DAY_W       = OFFSET_BITS - 15;
	localparam int XW          = OFFSET_BITS - 7;
	localparam int QW          = OFFSET_BITS - 16;
	localparam int RCP_SH      = OFFSET_BITS + 3;
	localparam int RCP_W       = OFFSET_BITS - 6;
	localparam int DPW         = XW + RCP_W;
	localparam int YMOD_W      = 9;
	localparam int IDX_W       = 3;
	localparam int CFG_W       = 14;

	localparam int DAYS_PER_CYCLE = 146097;

	// Reciprocals are rounded up; each one is exact over the range it is applied to.
	localparam logic [RCP_W-1:0] RCP_675 = RCP_W'(((longint'(1) << RCP_SH) + 674) / 675);
	localparam logic [9:0]       RCP_25  = 10'd656;
	localparam logic [13:0]      RCP_225 = 14'd9321;
	localparam logic [12:0]      RCP_60  = 13'd4370;

	localparam logic [19:0] MICRO_MAX     = 20'd999999;
	localparam logic [19:0] MICRO_PER_SEC = 20'd1000000;

	localparam logic [IDX_W-1:0] REG_BASE_YEAR   = 3'd0;
	localparam logic [IDX_W-1:0] REG_BASE_MONTH  = 3'd1;
	localparam logic [IDX_W-1:0] REG_BASE_DAY    = 3'd2;
	localparam logic [IDX_W-1:0] REG_BASE_HOUR   = 3'd3;
	localparam logic [IDX_W-1:0] REG_BASE_MINUTE = 3'd4;
	localparam logic [IDX_W-1:0] REG_BASE_SECOND = 3'd5;

	localparam logic [3:0] OP_NONE  = 4'd0;
	localparam logic [3:0] OP_LOAD  = 4'd1;
	localparam logic [3:0] OP_QUO   = 4'd2;
	localparam logic [3:0] OP_REM   = 4'd3;
	localparam logic [3:0] OP_HOUR  = 4'd4;
	localparam logic [3:0] OP_HREM  = 4'd5;
	localparam logic [3:0] OP_MIN   = 4'd6;
	localparam logic [3:0] OP_SEC   = 4'd7;
	localparam logic [3:0] OP_TIME  = 4'd8;
	localparam logic [3:0] OP_CYCLE = 4'd9;
	localparam logic [3:0] OP_WALK  = 4'd10;

	typedef struct packed {
		logic [3:0] op;
	} cmd_t;

	typedef struct packed {
		logic cyc_more;
		logic walk_more;
	} sts_t;

	typedef struct packed {
		logic            is_negative;
		logic [WS_W-1:0] whole_seconds;
		logic [19:0]     micro_seconds;
	} in_t;

	typedef struct packed {
		logic signed [14:0] out_year;
		logic [3:0]         out_month;
		logic [4:0]         out_day;
		logic [4:0]         out_hour;
		logic [5:0]         out_minute;
		logic [5:0]         out_second;
		logic [19:0]        out_micro;
	} out_t;

	// Leap test on the year taken modulo 400.
	function automatic logic leap_f(input logic [YMOD_W-1:0] ymod);
		return (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200) &&
			(ymod != 9'd300);
	endfunction

	function automatic logic [4:0] mlen_f(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		unique case (m)
			4'd2: r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/dpso_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date plus seconds offset: controller
// Sequences the offset split, the time-of-day step, the 400-year cycle skip and the month walk.
// ----------------------------------------------------------------------------
module dpso_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	input  dpso_pkg::sts_t sts,
	output dpso_pkg::cmd_t cmd
);
	import dpso_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_QUO  = 4'd1;
	localparam logic [3:0] S_REM  = 4'd2;
	localparam logic [3:0] S_HOUR = 4'd3;
	localparam logic [3:0] S_HREM = 4'd4;
	localparam logic [3:0] S_MIN  = 4'd5;
	localparam logic [3:0] S_SEC  = 4'd6;
	localparam logic [3:0] S_TIME = 4'd7;
	localparam logic [3:0] S_CYC  = 4'd8;
	localparam logic [3:0] S_WALK = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	logic [3:0] state_q, state_nx;

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		state_nx = state_q;
		cmd.op   = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op   = OP_LOAD;
					state_nx = S_QUO;
				end
			end
			S_QUO: begin
				cmd.op   = OP_QUO;
				state_nx = S_REM;
			end
			S_REM: begin
				cmd.op   = OP_REM;
				state_nx = S_HOUR;
			end
			S_HOUR: begin
				cmd.op   = OP_HOUR;
				state_nx = S_HREM;
			end
			S_HREM: begin
				cmd.op   = OP_HREM;
				state_nx = S_MIN;
			end
			S_MIN: begin
				cmd.op   = OP_MIN;
				state_nx = S_SEC;
			end
			S_SEC: begin
				cmd.op   = OP_SEC;
				state_nx = S_TIME;
			end
			S_TIME: begin
				cmd.op   = OP_TIME;
				state_nx = S_CYC;
			end
			S_CYC: begin
				if (sts.cyc_more) cmd.op = OP_CYCLE;
				else state_nx = S_WALK;
			end
			S_WALK: begin
				cmd.op = OP_WALK;
				if (!sts.walk_more) state_nx = S_DONE;
			end
			S_DONE: state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted beat did not start work");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("controller not idle after result");
	a_walk_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK && !sts.walk_more |=> done)
		else $error("walk ended without a result");
`endif

endmodule

// ===== sv/dpso_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date plus seconds offset: datapath
// Base registers, reciprocal constant dividers, time-of-day carries, the 400-year cycle skip
// and the month-by-month day walk.
// ----------------------------------------------------------------------------
module dpso_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [dpso_pkg::IDX_W-1:0] cfg_index,
	input  logic [dpso_pkg::CFG_W-1:0] cfg_data,
	input  dpso_pkg::in_t              operand,
	input  dpso_pkg::cmd_t             cmd,
	output dpso_pkg::sts_t             sts,
	output dpso_pkg::out_t             result
);
	import dpso_pkg::*;

	logic [13:0] byear_q;
	logic [3:0]  bmon_q;
	logic [4:0]  bday_q;
	logic [4:0]  bhour_q;
	logic [5:0]  bmin_q;
	logic [5:0]  bsec_q;

	logic                   neg_q;
	logic [OFFSET_BITS-1:0] ws_q;
	logic [19:0]            us_q;
	logic [QW-1:0]          dq_q;
	logic [4:0]             yq_q;
	logic [16:0]            tod_q;
	logic [11:0]            remh_q;
	logic [5:0]             sec_off_q;
	logic [5:0]             min_off_q;
	logic [4:0]             hr_off_q;
	logic [DAY_W-1:0]       days_q;
	logic signed [14:0]     y_q;
	logic [YMOD_W-1:0]      ymod_q;
	logic [3:0]             m_q;
	logic [4:0]             d_q;
	logic [4:0]             h_q;
	logic [5:0]             mi_q;
	logic [5:0]             s_q;
	logic [19:0]            micro_q;

	logic [13:0] cl_year;
	logic [3:0]  cl_mon;
	logic [4:0]  cl_hour;
	logic [5:0]  cl_min;
	logic [5:0]  cl_sec;
	logic [4:0]  cl_day;
	logic [4:0]  base_ml;
	logic [19:0] us_cl;

	logic [XW-1:0]  x_day;
	logic [DPW-1:0] day_prod;
	logic [XW-1:0]  day_back;
	logic [9:0]     day_rem;
	logic [18:0]    y_prod;
	logic [13:0]    y_back;
	logic [25:0]    hr_prod;
	logic [16:0]    hr_back;
	logic [23:0]    mn_prod;
	logic [11:0]    mn_back;

	logic [6:0] s_sum, mi_sum;
	logic [5:0] h_sum;
	logic       c1, c2, c3;
	logic [7:0] s_dif, mi_dif;
	logic [6:0] h_dif;
	logic       b1, b2, b3, us_nz;
	logic       tcarry;

	logic [31:0]       days_wide;
	logic [4:0]        ml_cur, ml_prev;
	logic [5:0]        dd;
	logic [3:0]        m_prev;
	logic [YMOD_W-1:0] ymod_prev, ymod_next, yprev_sel;
	logic              fwd_more, bwd_more;

	assign cl_year = (byear_q == 14'd0) ? 14'd1 :
		(byear_q > 14'd9999) ? 14'd9999 : byear_q;
	assign cl_mon  = (bmon_q == 4'd0) ? 4'd1 : (bmon_q > 4'd12) ? 4'd12 : bmon_q;
	assign cl_hour = (bhour_q > 5'd23) ? 5'd23 : bhour_q;
	assign cl_min  = (bmin_q > 6'd59) ? 6'd59 : bmin_q;
	assign cl_sec  = (bsec_q > 6'd59) ? 6'd59 : bsec_q;
	assign base_ml = mlen_f(m_q, leap_f(ymod_q));
	assign cl_day  = (bday_q == 5'd0) ? 5'd1 : (bday_q > base_ml) ? base_ml : bday_q;
	assign us_cl   = (operand.micro_seconds > MICRO_MAX) ? MICRO_MAX :
		operand.micro_seconds;

	// Whole days: the offset over 128, then over 675, gives the offset over 86400.
	assign x_day    = ws_q[OFFSET_BITS-1:7];
	assign day_prod = DPW'(x_day) * DPW'(RCP_675);
	assign day_back = XW'(dq_q) * XW'(10'd675);
	assign day_rem  = 10'(x_day - day_back);

	// Year over 400 as the year over 16, then over 25.
	assign y_prod = 19'(y_q[13:4]) * 19'(RCP_25);
	assign y_back = 14'(yq_q) * 14'd400;

	assign hr_prod = 26'(tod_q[16:4]) * 26'(RCP_225);
	assign hr_back = 17'(hr_off_q) * 17'd3600;
	assign mn_prod = 24'(remh_q) * 24'(RCP_60);
	assign mn_back = 12'(min_off_q) * 12'd60;

	// Time of day, forward.
	assign s_sum  = {1'b0, s_q} + {1'b0, sec_off_q};
	assign c1     = (s_sum >= 7'd60);
	assign mi_sum = {1'b0, mi_q} + {1'b0, min_off_q} + {6'd0, c1};
	assign c2     = (mi_sum > 7'd59);
	assign h_sum  = {1'b0, h_q} + {1'b0, hr_off_q} + {5'd0, c2};
	assign c3     = (h_sum > 6'd23);

	// Time of day, backward.
	assign us_nz  = (us_q != 20'd0);
	assign s_dif  = {2'b00, s_q} - {2'b00, sec_off_q} - {7'd0, us_nz};
	assign b1     = s_dif[7];
	assign mi_dif = {2'b00, mi_q} - {2'b00, min_off_q} - {7'd0, b1};
	assign b2     = mi_dif[7];
	assign h_dif  = {2'b00, h_q} - {2'b00, hr_off_q} - {6'd0, b2};
	assign b3     = h_dif[6];

	assign tcarry = neg_q ? b3 : c3;

	assign days_wide = 32'(days_q);
	assign ml_cur    = mlen_f(m_q, leap_f(ymod_q));
	assign dd        = {1'b0, ml_cur} - {1'b0, d_q} + 6'd1;
	assign m_prev    = (m_q == 4'd1) ? 4'd12 : m_q - 4'd1;
	assign ymod_prev = (ymod_q == 9'd0) ? 9'd399 : ymod_q - 9'd1;
	assign ymod_next = (ymod_q == 9'd399) ? 9'd0 : ymod_q + 9'd1;
	assign yprev_sel = (m_q == 4'd1) ? ymod_prev : ymod_q;
	assign ml_prev   = mlen_f(m_prev, leap_f(yprev_sel));
	assign fwd_more  = (days_wide >= 32'(dd));
	assign bwd_more  = (days_wide > 32'(d_q));

	assign sts.cyc_more  = (days_wide >= 32'(DAYS_PER_CYCLE));
	assign sts.walk_more = neg_q ? bwd_more : fwd_more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byear_q <= 14'd1998;
			bmon_q  <= 4'd1;
			bday_q  <= 5'd1;
			bhour_q <= 5'd0;
			bmin_q  <= 6'd0;
			bsec_q  <= 6'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_YEAR:   byear_q <= cfg_data;
				REG_BASE_MONTH:  bmon_q  <= cfg_data[3:0];
				REG_BASE_DAY:    bday_q  <= cfg_data[4:0];
				REG_BASE_HOUR:   bhour_q <= cfg_data[4:0];
				REG_BASE_MINUTE: bmin_q  <= cfg_data[5:0];
				REG_BASE_SECOND: bsec_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				neg_q   <= operand.is_negative;
				ws_q    <= OFFSET_BITS'(operand.whole_seconds);
				us_q    <= us_cl;
				y_q     <= signed'({1'b0, cl_year});
				m_q     <= cl_mon;
				h_q     <= cl_hour;
				mi_q    <= cl_min;
				s_q     <= cl_sec;
			end
			OP_QUO: begin
				dq_q <= day_prod[DPW-1:RCP_SH];
				yq_q <= y_prod[18:14];
			end
			OP_REM: begin
				ymod_q <= 9'(y_q[13:0] - y_back);
				tod_q  <= {day_rem, ws_q[6:0]};
				days_q <= DAY_W'(dq_q);
			end
			OP_HOUR: begin
				hr_off_q <= hr_prod[25:21];
				d_q      <= cl_day;
			end
			OP_HREM: begin
				remh_q <= 12'(tod_q - hr_back);
			end
			OP_MIN: begin
				min_off_q <= mn_prod[23:18];
			end
			OP_SEC: begin
				sec_off_q <= 6'(remh_q - mn_back);
			end
			OP_TIME: begin
				days_q <= days_q + DAY_W'(tcarry);
				if (neg_q) begin
					s_q     <= b1 ? 6'(s_dif + 8'd60) : s_dif[5:0];
					mi_q    <= b2 ? 6'(mi_dif + 8'd60) : mi_dif[5:0];
					h_q     <= b3 ? 5'(h_dif + 7'd24) : h_dif[4:0];
					micro_q <= us_nz ? MICRO_PER_SEC - us_q : 20'd0;
					d_q     <= d_q - 5'd1;
				end else begin
					s_q     <= c1 ? 6'(s_sum - 7'd60) : s_sum[5:0];
					mi_q    <= c2 ? 6'(mi_sum - 7'd60) : mi_sum[5:0];
					h_q     <= c3 ? 5'(h_sum - 6'd24) : h_sum[4:0];
					micro_q <= us_q;
				end
			end
			OP_CYCLE: begin
				days_q <= days_q - DAY_W'(DAYS_PER_CYCLE);
				y_q    <= neg_q ? y_q - 15'sd400 : y_q + 15'sd400;
			end
			OP_WALK: begin
				if (neg_q) begin
					if (bwd_more) begin
						days_q <= days_q - DAY_W'(d_q);
						m_q    <= m_prev;
						d_q    <= ml_prev;
						if (m_q == 4'd1) begin
							y_q    <= y_q - 15'sd1;
							ymod_q <= ymod_prev;
						end
					end else begin
						d_q <= d_q - 5'(days_q) + 5'd1;
					end
				end else begin
					if (fwd_more) begin
						days_q <= days_q - DAY_W'(dd);
						d_q    <= 5'd1;
						if (m_q == 4'd12) begin
							m_q    <= 4'd1;
							y_q    <= y_q + 15'sd1;
							ymod_q <= ymod_next;
						end else begin
							m_q <= m_q + 4'd1;
						end
					end else begin
						d_q <= d_q + 5'(days_q);
					end
				end
			end
			default: ;
		endcase
	end

	assign result.out_year   = y_q;
	assign result.out_month  = m_q;
	assign result.out_day    = d_q;
	assign result.out_hour   = h_q;
	assign result.out_minute = mi_q;
	assign result.out_second = s_q;
	assign result.out_micro  = micro_q;

`ifndef ASSERT_OFF
	a_split_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_HOUR |-> tod_q < 17'd86400 && ymod_q < 9'd400)
		else $error("time of day or year phase out of range");
	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_TIME |-> sec_off_q < 6'd60 && min_off_q < 6'd60 && hr_off_q < 5'd24)
		else $error("offset fields out of range");
	a_walk_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_WALK |-> m_q >= 4'd1 && m_q <= 4'd12 && ymod_q < 9'd400 &&
		d_q <= ml_cur) else $error("calendar state out of range during walk");
	a_final_day: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_WALK && !sts.walk_more |=> d_q >= 5'd1 && d_q <= $past(ml_cur))
		else $error("final day outside its month");
`endif

endmodule

// ===== sv/date_plus_seconds_offset.sv =====
`timescale 1ns / 1ps
// From the accepted start beat to done: six fixed steps split the offset by reciprocal
// multiplication, then a time-of-day step, a skip of K 400-year cycles and the
// one-month-per-cycle walk across N month boundaries (N at most about 4800).
// The receiver cannot stall.
// One item at a time: busy stays high until done; the result holds until the next start.
// Reset is asynchronous, active low; the base registers return to 1998-01-01 00:00:00.
// ----------------------------------------------------------------------------
// Date plus seconds offset
// Adds or subtracts a seconds offset to a configured base date and time.
// ----------------------------------------------------------------------------
module date_plus_seconds_offset (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  dpso_pkg::in_t              operand,
	output logic                       done,
	output dpso_pkg::out_t             result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [dpso_pkg::IDX_W-1:0] cfg_index,
	input  logic [dpso_pkg::CFG_W-1:0] cfg_data
);
	import dpso_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	dpso_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	dpso_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.operand   (operand),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

endmodule
